@@ rtl/core/riu_pkg.sv @@
// Package for the integer upscaler: widths, register indexes, defaults and the pixel mean.
package riu_pkg;

	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int SCALE_W    = 3;
	localparam int DIM_W      = 11;
	localparam int COORD_W    = 12;
	localparam int ROW_W      = 10;
	localparam int MAX_HEIGHT = 1024;
	localparam int REG_IDX_W  = 2;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_SCALE_DEF = 4;

	localparam logic [REG_IDX_W-1:0] REG_SCALE      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_RST  = 3'd2;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd480;

	typedef logic [PIX_W-1:0] pixel_t;

	// Per-channel floored mean of two packed BGR pixels.
	function automatic pixel_t mean_px(pixel_t a, pixel_t b);
		logic [CHAN_W:0] sum;
		pixel_t          res;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			sum = {1'b0, a[k*CHAN_W +: CHAN_W]} + {1'b0, b[k*CHAN_W +: CHAN_W]};
			res[k*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
		end
		return res;
	endfunction

endpackage

@@ rtl/core/rgb_image_integer_upscaler.sv @@
// Integer-factor BGR image upscaler with a one-row line memory and a result sequencer.
//
//  Channel   Signals                                   Direction  Moves
//  config    cfg_we, cfg_index, cfg_data               in         one register write
//  input     in_valid/in_ready, blue/green/red_in      in         one source pixel request
//  output    out_valid/out_ready, out_x, out_y,        out        one enlarged pixel request
//            blue/green/red_out, block_last
//
// A source pixel request yields nx*ny results (1 to (2*MAX_SCALE-1)^2); an interior pixel
// yields scale^2 of them. The result register issues one result per cycle while the
// output is not stalled. After acceptance a request passes stage 1, with the line memory
// read, then stage 2, whose sequencer loads each of its results into the result register.
// The line memory is read and written at the same address in the acceptance cycle
// (read-first), so no forwarding is needed. It is not cleared after reset.
// Stalls on the output freeze the sequencer; the input stage keeps one request in flight
// behind the one being expanded, so a new request is taken while results still wait.
module rgb_image_integer_upscaler #(
	parameter int MAX_WIDTH = riu_pkg::MAX_WIDTH_DEF,
	parameter int MAX_SCALE = riu_pkg::MAX_SCALE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [riu_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [riu_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [riu_pkg::CHAN_W-1:0]    blue_in,
	input  logic [riu_pkg::CHAN_W-1:0]    green_in,
	input  logic [riu_pkg::CHAN_W-1:0]    red_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [riu_pkg::COORD_W-1:0]   out_x,
	output logic [riu_pkg::COORD_W-1:0]   out_y,
	output logic [riu_pkg::CHAN_W-1:0]    blue_out,
	output logic [riu_pkg::CHAN_W-1:0]    green_out,
	output logic [riu_pkg::CHAN_W-1:0]    red_out,
	output logic                          block_last
);
	import riu_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int NW  = $clog2(2 * MAX_SCALE);
	localparam int PXW = CW + SCALE_W;
	localparam int PYW = ROW_W + SCALE_W;

	// Configuration registers.
	logic [SCALE_W-1:0] scale_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;

	// Effective, clamped configuration.
	logic [SCALE_W-1:0] s_eff;
	logic [SCALE_W-1:0] s_m1;
	logic [WW-1:0]      w_eff;
	logic [DIM_W-1:0]   h_eff;

	always_comb begin
		if (scale_q == '0)
			s_eff = SCALE_W'(1);
		else if (scale_q > SCALE_W'(MAX_SCALE))
			s_eff = SCALE_W'(MAX_SCALE);
		else
			s_eff = scale_q;
		s_m1 = s_eff - SCALE_W'(1);

		if (width_q == '0)
			w_eff = WW'(1);
		else if (WW'(width_q) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);

		if (height_q == '0)
			h_eff = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// Raster position of the next source pixel.
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    c_cur;
	logic [ROW_W-1:0] r_cur;
	logic             col_last;
	logic             row_last;

	always_comb begin
		c_cur    = (WW'(col_q) >= w_eff) ? '0 : col_q;
		r_cur    = (DIM_W'(row_q) >= h_eff) ? '0 : row_q;
		col_last = (WW'(c_cur) + WW'(1)) >= w_eff;
		row_last = (DIM_W'(r_cur) + DIM_W'(1)) >= h_eff;
	end

	pixel_t pix_in;
	assign pix_in = {red_in, green_in, blue_in};

	// Stage and handshake control.
	logic             valid_s1;
	logic             valid_s2;
	logic             out_valid_q;
	logic             emit;
	logic             s2_last;
	logic             s2_done;
	logic             s1_move;
	logic             in_acc;

	assign emit     = valid_s2 && (!out_valid_q || out_ready);
	assign s2_done  = emit && s2_last;
	assign s1_move  = valid_s1 && (!valid_s2 || s2_done);
	assign in_ready = !valid_s1 || s1_move;
	assign in_acc   = in_valid && in_ready;

	// Configuration writes and the raster counters. Any write to a mapped register starts a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (in_acc) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : r_cur + ROW_W'(1);
				end else begin
					col_q <= c_cur + CW'(1);
					row_q <= r_cur;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCALE: begin
						scale_q <= cfg_data[SCALE_W-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_SRC_WIDTH: begin
						width_q <= cfg_data;
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_SRC_HEIGHT: begin
						height_q <= cfg_data;
						col_q    <= '0;
						row_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Line memory holding the previous source row. Read-first at the shared address:
	// the read returns the pixel above, the write stores the current one.
	pixel_t mem [MAX_WIDTH];
	pixel_t rd_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q       <= mem[c_cur];
			mem[c_cur] <= pix_in;
		end
	end

	// Stage 1: the request waits here while its line memory read completes.
	pixel_t           pix_s1;
	pixel_t           left_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             col_last_s1;
	logic             row_last_s1;
	pixel_t           left_q;
	pixel_t           above_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			left_q       <= '0;
			above_left_q <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				left_q   <= pix_in;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move)
				above_left_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= pix_in;
			left_s1     <= left_q;
			col_s1      <= c_cur;
			row_s1      <= r_cur;
			col_last_s1 <= col_last;
			row_last_s1 <= row_last;
		end
	end

	// Output span of the request: consecutive columns and rows starting at a base,
	// where the first k of each axis lie between two samples.
	logic [PXW-1:0]     prod_x;
	logic [PYW-1:0]     prod_y;
	logic [COORD_W-1:0] xb_d;
	logic [COORD_W-1:0] yb_d;
	logic [NW-1:0]      kx_d;
	logic [NW-1:0]      ky_d;
	logic [NW-1:0]      nx_d;
	logic [NW-1:0]      ny_d;

	always_comb begin
		prod_x = PXW'(col_s1) * PXW'(s_eff);
		prod_y = PYW'(row_s1) * PYW'(s_eff);
		xb_d   = (col_s1 != '0) ? COORD_W'(prod_x - PXW'(s_eff) + PXW'(1)) : '0;
		yb_d   = (row_s1 != '0) ? COORD_W'(prod_y - PYW'(s_eff) + PYW'(1)) : '0;
		kx_d   = (col_s1 != '0) ? NW'(s_m1) : '0;
		ky_d   = (row_s1 != '0) ? NW'(s_m1) : '0;
		nx_d   = kx_d + NW'(1) + (col_last_s1 ? NW'(s_m1) : '0);
		ny_d   = ky_d + NW'(1) + (row_last_s1 ? NW'(s_m1) : '0);
	end

	// Stage 2: the sequencer walks the span row by row, left to right.
	pixel_t             pix_s2;
	pixel_t             above_s2;
	pixel_t             hmc_s2;
	pixel_t             hmu_s2;
	logic [COORD_W-1:0] xb_s2;
	logic [COORD_W-1:0] yb_s2;
	logic [NW-1:0]      kx_s2;
	logic [NW-1:0]      ky_s2;
	logic [NW-1:0]      nx_s2;
	logic [NW-1:0]      ny_s2;
	logic [NW-1:0]      ix_s2;
	logic [NW-1:0]      jy_s2;
	logic               last_x;
	logic               last_y;

	assign last_x  = ix_s2 == (nx_s2 - NW'(1));
	assign last_y  = jy_s2 == (ny_s2 - NW'(1));
	assign s2_last = last_x && last_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ix_s2    <= '0;
			jy_s2    <= '0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
			ix_s2    <= '0;
			jy_s2    <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (emit) begin
			if (last_x) begin
				ix_s2 <= '0;
				jy_s2 <= jy_s2 + NW'(1);
			end else begin
				ix_s2 <= ix_s2 + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pix_s2   <= pix_s1;
			above_s2 <= rd_q;
			hmc_s2   <= mean_px(left_s1, pix_s1);
			hmu_s2   <= mean_px(above_left_q, rd_q);
			xb_s2    <= xb_d;
			yb_s2    <= yb_d;
			kx_s2    <= kx_d;
			ky_s2    <= ky_d;
			nx_s2    <= nx_d;
			ny_s2    <= ny_d;
		end
	end

	// Value of the current result.
	pixel_t cur_px;
	pixel_t up_px;
	pixel_t val_px;

	always_comb begin
		cur_px = (ix_s2 < kx_s2) ? hmc_s2 : pix_s2;
		up_px  = (ix_s2 < kx_s2) ? hmu_s2 : above_s2;
		val_px = (jy_s2 < ky_s2) ? mean_px(up_px, cur_px) : cur_px;
	end

	// Result register.
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	pixel_t             out_px_q;
	logic               block_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q      <= xb_s2 + COORD_W'(ix_s2);
			out_y_q      <= yb_s2 + COORD_W'(jy_s2);
			out_px_q     <= val_px;
			block_last_q <= s2_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign blue_out   = out_px_q[CHAN_W-1:0];
	assign green_out  = out_px_q[2*CHAN_W-1:CHAN_W];
	assign red_out    = out_px_q[3*CHAN_W-1:2*CHAN_W];
	assign block_last = block_last_q;

`ifndef SYNTHESIS
	// The sequencer never walks past the span it was loaded with.
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (ix_s2 < nx_s2) && (jy_s2 < ny_s2))
		else $error("sequencer index outside its span");

	// Interpolated positions are always a strict prefix of each axis.
	a_kind_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (kx_s2 < nx_s2) && (ky_s2 < ny_s2))
		else $error("interpolated count not below span count");

	// Finishing a request places its marked last result in the result register.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		s2_done |=> out_valid_q && block_last_q)
		else $error("last result of a request not marked");

	// A pending result that is not the last of its request leaves its request in stage 2.
	a_open_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !block_last_q) |-> valid_s2)
		else $error("request left the sequencer before its last result");
`endif

endmodule

@@ sim/upscale_checker.sv @@
// Checker for the integer upscaler: predicts every enlarged pixel and compares the output stream.
module upscale_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [riu_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [riu_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [riu_pkg::CHAN_W-1:0]    blue_in,
	input  logic [riu_pkg::CHAN_W-1:0]    green_in,
	input  logic [riu_pkg::CHAN_W-1:0]    red_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [riu_pkg::COORD_W-1:0]   out_x,
	input  logic [riu_pkg::COORD_W-1:0]   out_y,
	input  logic [riu_pkg::CHAN_W-1:0]    blue_out,
	input  logic [riu_pkg::CHAN_W-1:0]    green_out,
	input  logic [riu_pkg::CHAN_W-1:0]    red_out,
	input  logic                          block_last,
	output int                            mismatch_count,
	output int                            pending_count,
	output int                            checked_count
);
	import riu_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  red;
		logic               last;
	} out_pixel_t;

	localparam int PRINT_CAP = 40;

	logic [SCALE_W-1:0] scale_reg;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	pixel_t             line_mem [MAX_WIDTH_DEF];
	pixel_t             left_px;
	pixel_t             above_left_px;
	int unsigned        col_idx;
	int unsigned        row_idx;
	out_pixel_t         expected_pixels [$];

	function automatic pixel_t blend(pixel_t a, pixel_t b);
		int     sum;
		pixel_t res;
		for (int k = 0; k < 3; k++) begin
			sum = a[k*CHAN_W +: CHAN_W] + b[k*CHAN_W +: CHAN_W];
			res[k*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
		end
		return res;
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				checked_count, name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		out_pixel_t  want;
		pixel_t      src;
		pixel_t      above;
		pixel_t      hm_cur;
		pixel_t      hm_up;
		pixel_t      cur;
		pixel_t      up;
		pixel_t      val;
		int unsigned s, w, h, c, r, x0, x1, y0, y1;
		if (!arst_n) begin
			scale_reg     = SCALE_RST;
			width_reg     = WIDTH_RST;
			height_reg    = HEIGHT_RST;
			left_px       = '0;
			above_left_px = '0;
			col_idx       = 0;
			row_idx       = 0;
			for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
				line_mem[i] = '0;
			end
			expected_pixels.delete();
			mismatch_count = 0;
			pending_count  = 0;
			checked_count  = 0;
		end else begin
			// Results are matched before new requests are expanded; a result never
			// belongs to a request taken at the same edge.
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) arrived with nothing expected",
						out_x, out_y));
				end else begin
					want = expected_pixels.pop_front();
					compare_field("out_x", 32'(out_x), 32'(want.x));
					compare_field("out_y", 32'(out_y), 32'(want.y));
					compare_field("blue_out", 32'(blue_out), 32'(want.blue));
					compare_field("green_out", 32'(green_out), 32'(want.green));
					compare_field("red_out", 32'(red_out), 32'(want.red));
					compare_field("block_last", 32'(block_last), 32'(want.last));
					checked_count++;
				end
			end

			// Any mapped register write restarts the frame; unmapped indexes do nothing.
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: begin
						scale_reg = cfg_data[SCALE_W-1:0];
						col_idx   = 0;
						row_idx   = 0;
					end
					REG_SRC_WIDTH: begin
						width_reg = cfg_data;
						col_idx   = 0;
						row_idx   = 0;
					end
					REG_SRC_HEIGHT: begin
						height_reg = cfg_data;
						col_idx    = 0;
						row_idx    = 0;
					end
					default: begin
					end
				endcase
			end

			if (in_valid && in_ready) begin
				s = clamp_dim(scale_reg, MAX_SCALE_DEF);
				w = clamp_dim(width_reg, MAX_WIDTH_DEF);
				h = clamp_dim(height_reg, MAX_HEIGHT);
				c = (col_idx >= w) ? 0 : col_idx;
				r = (row_idx >= h) ? 0 : row_idx;
				src    = {red_in, green_in, blue_in};
				above  = line_mem[c];
				hm_cur = blend(left_px, src);
				hm_up  = blend(above_left_px, above);
				// Span of output columns and rows settled by this pixel; the last
				// column and row also cover the replicated margin.
				x0 = (c > 0) ? (c - 1) * s + 1 : 0;
				x1 = (c == w - 1) ? c * s + s - 1 : c * s;
				y0 = (r > 0) ? (r - 1) * s + 1 : 0;
				y1 = (r == h - 1) ? r * s + s - 1 : r * s;
				for (int unsigned yy = y0; yy <= y1; yy++) begin
					for (int unsigned xx = x0; xx <= x1; xx++) begin
						cur = (xx < c * s) ? hm_cur : src;
						up  = (xx < c * s) ? hm_up : above;
						val = (yy < r * s) ? blend(up, cur) : cur;
						want.x     = COORD_W'(xx);
						want.y     = COORD_W'(yy);
						want.blue  = val[0 +: CHAN_W];
						want.green = val[CHAN_W +: CHAN_W];
						want.red   = val[2*CHAN_W +: CHAN_W];
						want.last  = (yy == y1) && (xx == x1);
						expected_pixels.push_back(want);
					end
				end
				above_left_px = above;
				line_mem[c]   = src;
				left_px       = src;
				if (c + 1 >= w) begin
					col_idx = 0;
					row_idx = (r + 1 >= h) ? 0 : r + 1;
				end else begin
					col_idx = c + 1;
					row_idx = r;
				end
			end
			pending_count = expected_pixels.size();
		end
	end

endmodule

@@ sim/tb_rgb_image_integer_upscaler.sv @@
// Testbench top for the integer upscaler: drives requests and register writes, gives the verdict.
module tb_rgb_image_integer_upscaler;
	import riu_pkg::*;

	// Index 3 is not mapped to any register; the block must drop writes to it.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// The limit allows for the slowest legal run: about 200 requests of
	// at most 49 results each, every result behind a long output stall.
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Extra wait at the end of a drain, with ample margin.
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 130;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SENDER_IDLE,
		FLOW_SINK_STALL,
		FLOW_BOTH_LIGHT
	} flow_mode_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index  = REG_SCALE;
	logic [DIM_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [CHAN_W-1:0]    blue_in    = '0;
	logic [CHAN_W-1:0]    green_in   = '0;
	logic [CHAN_W-1:0]    red_in     = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [COORD_W-1:0]   out_x;
	logic [COORD_W-1:0]   out_y;
	logic [CHAN_W-1:0]    blue_out;
	logic [CHAN_W-1:0]    green_out;
	logic [CHAN_W-1:0]    red_out;
	logic                 block_last;

	flow_mode_t flow_mode   = FLOW_FREE;
	int         pixels_sent = 0;
	int         setups      = 0;
	int         cycle_count = 0;
	int         mismatch_count;
	int         pending_count;
	int         checked_count;

	rgb_image_integer_upscaler u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.blue_in    (blue_in),
		.green_in   (green_in),
		.red_in     (red_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.blue_out   (blue_out),
		.green_out  (green_out),
		.red_out    (red_out),
		.block_last (block_last)
	);

	// The checker sees the same pins as the block and keeps the expected pixels.
	upscale_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blue_in        (blue_in),
		.green_in       (green_in),
		.red_in         (red_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_x          (out_x),
		.out_y          (out_y),
		.blue_out       (blue_out),
		.green_out      (green_out),
		.red_out        (red_out),
		.block_last     (block_last),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver side: in the stall modes, ready drops at random on each falling
	// edge, so stalls land on every phase of the expansion of a request.
	always @(negedge clk) begin
		case (flow_mode)
			FLOW_SINK_STALL: begin
				out_ready <= ($urandom_range(0, 99) >= 73);
			end
			FLOW_BOTH_LIGHT: begin
				out_ready <= ($urandom_range(0, 99) >= 7);
			end
			default: begin
				out_ready <= 1'b1;
			end
		endcase
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still outstanding",
				cycle_count, pending_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Channel values lean toward the extremes so that the floored means see
	// carries and all-ones bytes often.
	function automatic logic [CHAN_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return CHAN_W'($urandom);
			end
		endcase
	endfunction

	// Offers one source pixel request and returns at the falling edge after it was
	// accepted, with valid still high so back-to-back requests need no bubble.
	task automatic send_pixel(input logic [CHAN_W-1:0] b, g, r);
		int unsigned idle_pct;
		idle_pct = (flow_mode == FLOW_SENDER_IDLE) ? 73 :
			(flow_mode == FLOW_BOTH_LIGHT) ? 7 : 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < idle_pct) begin
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		blue_in  <= b;
		green_in <= g;
		red_in   <= r;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pixels_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected pixel has come out, then a few
	// more cycles so the block is truly idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers back to back. The scale register only keeps the
	// low bits, so the upper data bits carry noise.
	task automatic configure(input int unsigned scale_v, width_v, height_v);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_data  <= (DIM_W'($urandom) << SCALE_W) | DIM_W'(scale_v % 8);
		@(negedge clk);
		cfg_index <= REG_SRC_WIDTH;
		cfg_data  <= DIM_W'(width_v);
		@(negedge clk);
		cfg_index <= REG_SRC_HEIGHT;
		cfg_data  <= DIM_W'(height_v);
		@(negedge clk);
		cfg_we <= 1'b0;
		setups++;
	endtask

	// A write to the unmapped index must neither change a register nor restart
	// the frame, so it is placed in the middle of a frame.
	task automatic write_spare();
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_data  <= DIM_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		flow_mode_t  mode;
		int unsigned scale_v, width_v, height_v, count, eff_w, eff_h;
		int          phase;
		int          random_start;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero registers: scale, width and height all act as one, so every pixel
		// is a whole frame and is copied once.
		flow_mode <= FLOW_FREE;
		configure(0, 0, 0);
		send_pixel('0, '0, '0);
		send_pixel('1, '1, '1);
		send_pixel('1, '0, '1);

		// Scale above the limit acts as four; a 2x2 frame ends on a pixel that
		// carries both margins, the largest burst of results.
		flow_mode <= FLOW_SINK_STALL;
		configure(7, 2, 2);
		send_pixel('1, '1, '1);
		send_pixel('0, '0, '0);
		send_pixel('0, '1, '0);
		send_pixel('1, '0, '1);

		// Oversized width and height clamp to the maximum. Part way along the first
		// row the sender waits for all results, an unmapped write follows, and the
		// row must carry on from where it was.
		flow_mode <= FLOW_SENDER_IDLE;
		configure(3, 2047, 2047);
		send_pixel('1, '0, '0);
		send_pixel('0, '1, '0);
		send_pixel('0, '0, '1);
		write_spare();
		send_pixel('1, '1, '0);
		send_pixel('0, '1, '1);

		// Rewriting the registers mid-frame restarts it; a full 3x2 frame at scale
		// four then wraps into a new frame.
		flow_mode <= FLOW_BOTH_LIGHT;
		configure(4, 3, 2);
		repeat (8) send_pixel(pick_channel(), pick_channel(), pick_channel());

		// Random phases cycle through the flow modes. Most use small frames that are
		// completed once or twice, so both margins and frame wrap recur; a few use
		// huge or tall sizes with short bursts, and some end mid-frame.
		random_start = pixels_sent;
		phase = 0;
		while (pixels_sent - random_start < RANDOM_ITEMS) begin
			mode = flow_mode_t'(phase % 4);
			if ($urandom_range(0, 5) == 0) begin
				scale_v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7);
			end else begin
				scale_v = $urandom_range(1, 4);
			end
			case ($urandom_range(0, 9))
				0: begin
					width_v  = $urandom_range(1000, 2047);
					height_v = $urandom_range(1, 2047);
					count    = $urandom_range(2, 6);
				end
				1: begin
					width_v  = $urandom_range(1, 4);
					height_v = $urandom_range(1000, 2047);
					count    = $urandom_range(4, 12);
				end
				default: begin
					width_v  = $urandom_range(0, 6);
					height_v = $urandom_range(0, 5);
					eff_w    = (width_v == 0) ? 1 : width_v;
					eff_h    = (height_v == 0) ? 1 : height_v;
					count    = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, 2);
					if (count > 40) begin
						count = 40;
					end
				end
			endcase
			flow_mode <= mode;
			configure(scale_v, width_v, height_v);
			for (int i = 0; i < count; i++) begin
				// Every third phase halts mid-frame for a full drain and an
				// unmapped write, then resumes the same frame.
				if (phase % 3 == 1 && count > 1 && i == count / 2) begin
					write_spare();
				end
				send_pixel(pick_channel(), pick_channel(), pick_channel());
			end
			phase++;
		end

		drain();

		$display("Run covered %0d source pixels over %0d register setups; %0d enlarged pixels checked.",
			pixels_sent, setups, checked_count);
		$display("Scales and sizes reached both extremes, with free flow, sparse input and stalled output.");
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches found", mismatch_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
